// File: rtl/mfd_pkg.sv
package mfd_pkg;

   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned LEVEL_PORT_BITS = 2;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_PRIO = 2'd2
   } status_type;

   typedef enum logic {
      OP_ARRIVE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

endpackage

// File: rtl/multilevel_feedback_dispatcher.sv
// Four-level feedback job dispatcher. Each beat on start (taken whenever busy is low,
// and busy is always low) is an arrival or a scheduling tick, and yields exactly one
// result beat on rsp_valid, through the request register and the result register; a
// new beat may be given every cycle. The receiver cannot stall, so results must be
// taken on the cycle they appear. No beat holds up the next: the level FIFOs keep their
// head entry in a register and prefetch the next one from their memory, so a push, a
// pop and the level pick settle combinationally between the request register and the
// result register. No clearing pass is needed after reset.
module multilevel_feedback_dispatcher #(
   parameter int unsigned LEVELS      = 4,
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned ID_BITS     = 8,
   parameter int unsigned TIME_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic [ID_BITS-1:0]   req_job_id,
   input  logic [1:0]           req_priority_req,
   input  logic [TIME_BITS-1:0] req_service_time,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic                 rsp_running_valid,
   output logic [ID_BITS-1:0]   rsp_running_id,
   output logic [1:0]           rsp_running_level,
   output logic                 rsp_dispatched,
   output logic                 rsp_resumed,
   output logic                 rsp_preempted_valid,
   output logic [ID_BITS-1:0]   rsp_preempted_id,
   output logic                 rsp_terminated_valid,
   output logic [ID_BITS-1:0]   rsp_terminated_id
);

   localparam int unsigned LVL_BITS    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int unsigned ENTRY_BITS  = ID_BITS + TIME_BITS + 1;

   logic                 in_valid_ff;
   logic                 in_op_ff;
   logic [ID_BITS-1:0]   in_id_ff;
   logic [1:0]           in_prio_ff;
   logic [TIME_BITS-1:0] in_svc_ff;

   logic                 run_valid_ff, run_valid_in;
   logic [ID_BITS-1:0]   run_job_ff, run_job_in;
   logic [TIME_BITS-1:0] run_rem_ff, run_rem_in;
   logic [LVL_BITS-1:0]  run_level_ff, run_level_in;

   logic                 rsp_valid_ff;
   mfd_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                 rsp_running_valid_ff;
   logic [ID_BITS-1:0]   rsp_running_id_ff;
   logic [1:0]           rsp_running_level_ff;
   logic                 rsp_dispatched_ff, rsp_dispatched_in;
   logic                 rsp_resumed_ff, rsp_resumed_in;
   logic                 rsp_preempted_valid_ff, rsp_preempted_valid_in;
   logic [ID_BITS-1:0]   rsp_preempted_id_ff, rsp_preempted_id_in;
   logic                 rsp_terminated_valid_ff, rsp_terminated_valid_in;
   logic [ID_BITS-1:0]   rsp_terminated_id_ff, rsp_terminated_id_in;

   logic [ENTRY_BITS-1:0]  head [LEVELS];
   logic [LEVELS-1:0]      empty;
   logic [LEVELS-1:0]      full;
   mfd_pkg::fifo_ctl_type  ctl [LEVELS];

   logic                  push_v;
   logic [LVL_BITS-1:0]   push_lvl;
   logic [ENTRY_BITS-1:0] push_data;
   logic [LEVELS-1:0]     pop_vec;
   logic [LEVELS-1:0]     waiting;
   logic [LVL_BITS-1:0]   pick;
   logic [LVL_BITS-1:0]   tgt;
   logic [LVL_BITS-1:0]   prio_lvl;
   logic [TIME_BITS-1:0]  rem_dec;
   logic [TIME_BITS-1:0]  svc_fix;

   assign busy     = 1'b0;
   assign rem_dec  = run_rem_ff - TIME_BITS'(1);
   assign prio_lvl = LVL_BITS'(in_prio_ff);
   assign svc_fix  = (in_svc_ff == '0) ? TIME_BITS'(1) : in_svc_ff;
   assign tgt      = ((run_level_ff != '0) && (32'(run_level_ff) + 32'd1 < LEVELS))
                     ? run_level_ff + LVL_BITS'(1) : run_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      in_op_ff   <= req_opcode;
      in_id_ff   <= req_job_id;
      in_prio_ff <= req_priority_req;
      in_svc_ff  <= req_service_time;
   end

   always_comb begin
      rsp_status_in           = mfd_pkg::STATUS_OK;
      rsp_dispatched_in       = 1'b0;
      rsp_resumed_in          = 1'b0;
      rsp_preempted_valid_in  = 1'b0;
      rsp_preempted_id_in     = '0;
      rsp_terminated_valid_in = 1'b0;
      rsp_terminated_id_in    = '0;
      run_valid_in            = run_valid_ff;
      run_job_in              = run_job_ff;
      run_rem_in              = run_rem_ff;
      run_level_in            = run_level_ff;
      push_v                  = 1'b0;
      push_lvl                = '0;
      push_data               = '0;
      pop_vec                 = '0;
      waiting                 = '0;
      pick                    = '0;
      if (in_valid_ff) begin
         if (in_op_ff == mfd_pkg::OP_ARRIVE) begin
            if (32'(in_prio_ff) >= LEVELS) begin
               rsp_status_in = mfd_pkg::STATUS_BAD_PRIO;
            end else if (full[prio_lvl]) begin
               rsp_status_in = mfd_pkg::STATUS_FULL;
            end else begin
               push_v    = 1'b1;
               push_lvl  = prio_lvl;
               push_data = {in_id_ff, svc_fix, 1'b0};
            end
         end else begin
            if (run_valid_ff) begin
               if (run_rem_ff <= TIME_BITS'(1)) begin
                  run_rem_in              = '0;
                  rsp_terminated_valid_in = 1'b1;
                  rsp_terminated_id_in    = run_job_ff;
                  run_valid_in            = 1'b0;
               end else begin
                  run_rem_in = rem_dec;
                  if (!(&empty) && !full[tgt]) begin
                     push_v                 = 1'b1;
                     push_lvl               = tgt;
                     push_data              = {run_job_ff, rem_dec, 1'b1};
                     rsp_preempted_valid_in = 1'b1;
                     rsp_preempted_id_in    = run_job_ff;
                     run_valid_in           = 1'b0;
                  end
               end
            end
            if (!run_valid_in) begin
               waiting = ~empty;
               if (push_v) begin
                  waiting[push_lvl] = 1'b1;
               end
               for (int i = LEVELS - 1; i >= 0; i--) begin
                  if (waiting[i]) begin
                     pick = LVL_BITS'(i);
                  end
               end
               if (|waiting) begin
                  run_valid_in      = 1'b1;
                  run_level_in      = pick;
                  rsp_dispatched_in = 1'b1;
                  if (push_v && (push_lvl == pick) && empty[pick]) begin
                     push_v         = 1'b0;
                     rsp_resumed_in = 1'b1;
                  end else begin
                     pop_vec[pick] = 1'b1;
                     {run_job_in, run_rem_in, rsp_resumed_in} = head[pick];
                  end
               end
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         ctl[i].push = push_v && (push_lvl == LVL_BITS'(i));
         ctl[i].pop  = pop_vec[i];
      end
   end

   for (genvar g = 0; g < LEVELS; g++) begin : g_level
      mfd_level_fifo #(
         .DEPTH (QUEUE_DEPTH),
         .WIDTH (ENTRY_BITS)
      ) u_fifo (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[g]),
         .push_data (push_data),
         .head      (head[g]),
         .empty     (empty[g]),
         .full      (full[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         run_job_ff   <= '0;
         run_rem_ff   <= '0;
         run_level_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            run_valid_ff <= run_valid_in;
            run_job_ff   <= run_job_in;
            run_rem_ff   <= run_rem_in;
            run_level_ff <= run_level_in;
         end
      end
      rsp_status_ff           <= rsp_status_in;
      rsp_running_valid_ff    <= run_valid_in;
      rsp_running_id_ff       <= run_valid_in ? run_job_in : '0;
      rsp_running_level_ff    <= run_valid_in ? 2'(32'(run_level_in)) : 2'd0;
      rsp_dispatched_ff       <= rsp_dispatched_in;
      rsp_resumed_ff          <= rsp_resumed_in;
      rsp_preempted_valid_ff  <= rsp_preempted_valid_in;
      rsp_preempted_id_ff     <= rsp_preempted_id_in;
      rsp_terminated_valid_ff <= rsp_terminated_valid_in;
      rsp_terminated_id_ff    <= rsp_terminated_id_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_running_valid    = rsp_running_valid_ff;
   assign rsp_running_id       = rsp_running_id_ff;
   assign rsp_running_level    = rsp_running_level_ff;
   assign rsp_dispatched       = rsp_dispatched_ff;
   assign rsp_resumed          = rsp_resumed_ff;
   assign rsp_preempted_valid  = rsp_preempted_valid_ff;
   assign rsp_preempted_id     = rsp_preempted_id_ff;
   assign rsp_terminated_valid = rsp_terminated_valid_ff;
   assign rsp_terminated_id    = rsp_terminated_id_ff;

endmodule

// File: rtl/mfd_level_fifo.sv
module mfd_level_fifo #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mfd_pkg::fifo_ctl_type ctl,
   input  logic [WIDTH-1:0]     push_data,
   output logic [WIDTH-1:0]     head,
   output logic                 empty,
   output logic                 full
);

   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0]    mem [DEPTH];
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PTR_BITS-1:0] rp_ff, rp_in;
   logic [PTR_BITS-1:0] wp_ff, wp_in;
   logic [WIDTH-1:0]    head_ff, head_in;
   logic [WIDTH-1:0]    rd_ff;
   logic                cnt_zero, cnt_one;
   logic                wr_en, rd_adv;

   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (32'(p) + 32'd1 >= DEPTH) begin
         r = '0;
      end else begin
         r = p + PTR_BITS'(1);
      end
      return r;
   endfunction

   assign cnt_zero = (cnt_ff == '0);
   assign cnt_one  = (cnt_ff == CNT_BITS'(1));
   assign wr_en    = ctl.push && !cnt_zero && !(ctl.pop && cnt_one);
   assign rd_adv   = ctl.pop && !cnt_zero && !cnt_one;
   assign rp_in    = rd_adv ? ptr_inc(rp_ff) : rp_ff;
   assign wp_in    = wr_en ? ptr_inc(wp_ff) : wp_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      if (ctl.push && !ctl.pop) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end else if (ctl.pop && !ctl.push) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
      if (ctl.push && (cnt_zero || (ctl.pop && cnt_one))) begin
         head_in = push_data;
      end else if (rd_adv) begin
         head_in = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff  <= '0;
         wp_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
      end
      head_ff <= head_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= push_data;
      end
      if (wr_en && (wp_ff == rp_in)) begin
         rd_ff <= push_data;
      end else begin
         rd_ff <= mem[rp_in];
      end
   end

   assign head  = head_ff;
   assign empty = cnt_zero;
   assign full  = (32'(cnt_ff) >= DEPTH);

endmodule

// File: rtl/mfd_checker.sv
module mfd_checker #(
   parameter int unsigned ID_BITS = 8
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [1:0]         rsp_status,
   input logic               rsp_running_valid,
   input logic [ID_BITS-1:0] rsp_running_id,
   input logic               rsp_dispatched,
   input logic               rsp_resumed,
   input logic               rsp_preempted_valid,
   input logic               rsp_terminated_valid
);

   a_beat_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted beat produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted beat");

   a_resume_dispatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_resumed) |-> (rsp_dispatched && rsp_running_valid))
      else $error("resume without dispatch");

   a_preempt_redispatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_preempted_valid) |->
         (rsp_dispatched && rsp_running_valid && !rsp_terminated_valid))
      else $error("preemption left the processor idle");

   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != 2'(mfd_pkg::STATUS_OK))) |->
         (!rsp_dispatched && !rsp_preempted_valid && !rsp_terminated_valid
          && (rsp_running_valid || (rsp_running_id == '0))))
      else $error("rejected arrival changed scheduling");

endmodule

bind multilevel_feedback_dispatcher mfd_checker #(.ID_BITS(ID_BITS)) u_mfd_checker (.*);

// File: verif/multilevel_feedback_dispatcher_test.sv
module multilevel_feedback_dispatcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVEL_COUNT = 4;
   localparam int FIFO_DEPTH  = 16;
   localparam int ITEM_TARGET = 450;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] remaining;
      logic        started;
   } job_type;

   typedef struct packed {
      logic [1:0] status;
      logic       run_valid;
      logic [7:0] run_id;
      logic [1:0] run_level;
      logic       dispatched;
      logic       resumed;
      logic       pre_valid;
      logic [7:0] pre_id;
      logic       term_valid;
      logic [7:0] term_id;
   } outcome_type;

   class job_schedule_tracker;
      job_type     level_fifo[LEVEL_COUNT][$];
      bit          cpu_busy;
      job_type     cpu_job;
      logic [1:0]  cpu_level;
      outcome_type expected_outcomes[$];
      int          error_count;

      function int highest_waiting();
         for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
            if (level_fifo[lvl].size() != 0) return lvl;
         end
         return -1;
      endfunction

      function void predict_beat(mfd_pkg::opcode_type op, logic [7:0] id, logic [1:0] prio,
                                 logic [15:0] svc);
         outcome_type res;
         job_type     fresh;
         int          tgt;
         int          pick;
         res = '0;
         if (op == mfd_pkg::OP_ARRIVE) begin
            fresh.id = id;
            fresh.remaining = (svc == 16'd0) ? 16'd1 : svc;
            fresh.started = 1'b0;
            if (int'(prio) >= LEVEL_COUNT) begin
               res.status = mfd_pkg::STATUS_BAD_PRIO;
            end else if (level_fifo[prio].size() >= FIFO_DEPTH) begin
               res.status = mfd_pkg::STATUS_FULL;
            end else begin
               level_fifo[prio].push_back(fresh);
            end
         end else begin
            if (cpu_busy) begin
               if (cpu_job.remaining <= 16'd1) begin
                  res.term_valid = 1'b1;
                  res.term_id = cpu_job.id;
                  cpu_busy = 1'b0;
               end else begin
                  cpu_job.remaining--;
                  if (highest_waiting() >= 0) begin
                     tgt = cpu_level;
                     if (tgt != 0 && tgt + 1 < LEVEL_COUNT) tgt++;
                     if (level_fifo[tgt].size() < FIFO_DEPTH) begin
                        cpu_job.started = 1'b1;
                        level_fifo[tgt].push_back(cpu_job);
                        res.pre_valid = 1'b1;
                        res.pre_id = cpu_job.id;
                        cpu_busy = 1'b0;
                     end
                  end
               end
            end
            if (!cpu_busy) begin
               pick = highest_waiting();
               if (pick >= 0) begin
                  cpu_job = level_fifo[pick].pop_front();
                  cpu_level = pick[1:0];
                  cpu_busy = 1'b1;
                  res.dispatched = 1'b1;
                  res.resumed = cpu_job.started;
               end
            end
         end
         res.run_valid = cpu_busy;
         res.run_id = cpu_busy ? cpu_job.id : 8'd0;
         res.run_level = cpu_busy ? cpu_level : 2'd0;
         expected_outcomes.push_back(res);
      endfunction

      function void compare_field(string field, logic [15:0] exp, logic [15:0] act);
         if (exp !== act) begin
            $display("%0t: %s mismatch expected %0h actual %0h", $time, field, exp, act);
            error_count++;
         end
      endfunction

      function void check_result(outcome_type act);
         outcome_type exp;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected result beat expected none actual %0h", $time, act);
            error_count++;
            return;
         end
         exp = expected_outcomes.pop_front();
         compare_field("status", exp.status, act.status);
         compare_field("running_valid", exp.run_valid, act.run_valid);
         compare_field("running_id", exp.run_id, act.run_id);
         compare_field("running_level", exp.run_level, act.run_level);
         compare_field("dispatched", exp.dispatched, act.dispatched);
         compare_field("resumed", exp.resumed, act.resumed);
         compare_field("preempted_valid", exp.pre_valid, act.pre_valid);
         compare_field("preempted_id", exp.pre_id, act.pre_id);
         compare_field("terminated_valid", exp.term_valid, act.term_valid);
         compare_field("terminated_id", exp.term_id, act.term_id);
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_opcode = 1'b0;
   logic [7:0]  req_job_id = 8'd0;
   logic [1:0]  req_priority_req = 2'd0;
   logic [15:0] req_service_time = 16'd0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_running_valid;
   logic [7:0]  rsp_running_id;
   logic [1:0]  rsp_running_level;
   logic        rsp_dispatched;
   logic        rsp_resumed;
   logic        rsp_preempted_valid;
   logic [7:0]  rsp_preempted_id;
   logic        rsp_terminated_valid;
   logic [7:0]  rsp_terminated_id;

   job_schedule_tracker tracker = new();
   int                  items_sent;

   multilevel_feedback_dispatcher dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_job_id(req_job_id),
      .req_priority_req(req_priority_req),
      .req_service_time(req_service_time),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_running_valid(rsp_running_valid),
      .rsp_running_id(rsp_running_id),
      .rsp_running_level(rsp_running_level),
      .rsp_dispatched(rsp_dispatched),
      .rsp_resumed(rsp_resumed),
      .rsp_preempted_valid(rsp_preempted_valid),
      .rsp_preempted_id(rsp_preempted_id),
      .rsp_terminated_valid(rsp_terminated_valid),
      .rsp_terminated_id(rsp_terminated_id)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.check_result({rsp_status, rsp_running_valid, rsp_running_id,
                               rsp_running_level, rsp_dispatched, rsp_resumed,
                               rsp_preempted_valid, rsp_preempted_id,
                               rsp_terminated_valid, rsp_terminated_id});
      end
   end

   task automatic send_beat(mfd_pkg::opcode_type op, logic [7:0] id, logic [1:0] prio,
                            logic [15:0] svc);
      @(negedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_job_id <= id;
      req_priority_req <= prio;
      req_service_time <= svc;
      do @(posedge clock); while (busy);
      tracker.predict_beat(op, id, prio, svc);
      items_sent++;
   endtask

   task automatic hold_idle(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      hold_idle(1);
      while (tracker.pending() != 0 && guard < 200) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic send_arrival(int level);
      logic [15:0] svc;
      case ($urandom_range(0, 15))
         0: svc = 16'd0;
         1, 2: svc = 16'($urandom_range(0, 65535));
         default: svc = 16'($urandom_range(1, 8));
      endcase
      send_beat(mfd_pkg::OP_ARRIVE, 8'($urandom_range(0, 255)), 2'(level), svc);
   endtask

   task automatic send_noise_tick();
      send_beat(mfd_pkg::OP_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                16'($urandom_range(0, 65535)));
   endtask

   initial begin
      int mode;
      int burst;
      int level;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_ARRIVE, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_TICK, 8'hFF, 2'd3, 16'hFFFF);
      send_beat(mfd_pkg::OP_ARRIVE, 8'hFF, 2'd1, 16'hFFFF);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_ARRIVE, 8'h5A, 2'd1, 16'h0002);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_ARRIVE, 8'hA5, 2'd3, 16'h0003);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_ARRIVE, 8'h81, 2'd0, 16'h0001);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_ARRIVE, 8'h7E, 2'd0, 16'h0005);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         mode = $urandom_range(0, 9);
         burst = $urandom_range(1, 12);
         level = $urandom_range(0, 3);
         case (mode)
            0, 1: begin
               // fill one level past its depth, then let it run
               repeat ($urandom_range(FIFO_DEPTH + 1, FIFO_DEPTH + 3)) send_arrival(level);
               if (level != 0) send_arrival(level - 1);
               repeat ($urandom_range(1, 4)) begin
                  send_beat(mfd_pkg::OP_TICK, 8'h00, 2'd0, 16'h0000);
               end
            end
            2, 3: begin
               repeat (burst) send_noise_tick();
            end
            4: begin
               repeat (burst) send_arrival(level);
            end
            default: begin
               repeat (burst) begin
                  if ($urandom_range(0, 1)) send_noise_tick();
                  else send_arrival($urandom_range(0, 3));
               end
            end
         endcase
         if ($urandom_range(0, 14) == 0) wait_drained();
         else if ($urandom_range(0, 3) != 0) hold_idle($urandom_range(1, 6));
      end

      wait_drained();
      repeat (6) @(posedge clock);
      if (tracker.pending() != 0) begin
         $display("%0t: results missing expected %0d actual 0", $time, tracker.pending());
         tracker.error_count++;
      end
      if (tracker.error_count == 0) begin
         $display("multilevel_feedback_dispatcher_test OK");
      end else begin
         $display("multilevel_feedback_dispatcher_test NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("multilevel_feedback_dispatcher_test NOT OK");
      $finish;
   end

endmodule

// File: sim.f
rtl/mfd_pkg.sv
rtl/mfd_level_fifo.sv
rtl/multilevel_feedback_dispatcher.sv
rtl/mfd_checker.sv
verif/multilevel_feedback_dispatcher_test.sv
